>>> sv/asc_pkg.sv
// asc_pkg: shared types, codes and the header adjustment function for the
// aligned stack allocator. No dependencies.
package asc_pkg;

   localparam int HEADER_BYTES = 1;
   localparam int ADJ_W        = 8;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [1:0] CSR_REGION_BASE  = 2'd0;
   localparam logic [1:0] CSR_REGION_BYTES = 2'd1;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_REGION_FULL = 2'd1,
      ST_STACK_FULL  = 2'd2,
      ST_EMPTY       = 2'd3
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stack_cmd_type;

   // padding from top to next aligned address, bumped by whole alignments
   // until at least HEADER_BYTES of room sit below the block
   function automatic logic [ADJ_W-1:0] header_adjust(input logic [6:0] top_lo,
                                                      input logic [2:0] align_log2);
      logic [8:0] mask;
      logic [8:0] adj0;
      logic [8:0] need;
      logic [8:0] steps;
      logic [8:0] adj;
      mask  = (9'd1 << align_log2) - 9'd1;
      adj0  = {2'b00, 7'(7'd0 - top_lo)} & mask;
      need  = 9'(HEADER_BYTES) - adj0;
      steps = (need + mask) >> align_log2;
      adj   = adj0;
      if (adj0 < 9'(HEADER_BYTES)) begin
         adj = adj0 + (steps << align_log2);
      end
      return adj[ADJ_W-1:0];
   endfunction

endpackage

>>> sv/asc_ram.sv
// asc_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module asc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/asc_stack.sv
// asc_stack: adjustment stack with the top entry cached in a register and
// the rest in asc_ram, prefetching the entry below the top. Uses asc_pkg.
module asc_stack #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  asc_pkg::stack_cmd_type          cmd,
   input  logic [asc_pkg::ADJ_W-1:0]       push_data,
   output logic [$clog2(MAX_BLOCKS+1)-1:0] count,
   output logic [$clog2(MAX_BLOCKS+1)-1:0] count_next,
   output logic [asc_pkg::ADJ_W-1:0]       top_data
);
   import asc_pkg::*;

   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int AW = $clog2(MAX_BLOCKS);

   logic [CW-1:0]    count_ff, count_in;
   logic [ADJ_W-1:0] cache_ff, cache_in;
   logic             byp_ff;
   logic [ADJ_W-1:0] byp_data_ff;
   logic [ADJ_W-1:0] below;
   logic [ADJ_W-1:0] rd_data;
   logic [CW-1:0]    wr_idx;
   logic [CW-1:0]    rd_idx;
   logic             wr_en;

   // entry just under the top: ram prefetch, or the value written last cycle
   assign below = byp_ff ? byp_data_ff : rd_data;

   always_comb begin
      count_in = count_ff;
      cache_in = cache_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + CW'(1);
         cache_in = push_data;
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
         cache_in = below;
      end
   end

   // old cached top spills into the ram on a push onto a non-empty stack
   assign wr_en  = cmd.push && !cmd.clear && (count_ff != '0);
   assign wr_idx = count_ff - CW'(1);
   assign rd_idx = (count_in >= CW'(2)) ? (count_in - CW'(2)) : '0;

   asc_ram #(
      .WIDTH(ADJ_W),
      .DEPTH(MAX_BLOCKS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx[AW-1:0]),
      .wr_data(cache_ff),
      .rd_addr(rd_idx[AW-1:0]),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         byp_ff   <= wr_en;
      end
      cache_ff    <= cache_in;
      byp_data_ff <= cache_ff;
   end

   assign count      = count_ff;
   assign count_next = count_in;
   assign top_data   = cache_ff;

endmodule

>>> sv/aligned_stack_allocator.sv
// aligned_stack_allocator: top level of the LIFO bump allocator with header
// alignment. Uses asc_pkg, asc_stack and asc_ram.
//
// One request word is taken in every cycle (busy stays low) and its response
// word passes the input and response registers to rsp_, held for one cycle
// under rsp_strobe; the receiver cannot stall it. The whole decision for a
// request is one registered pass: header adjustment from the low top bits,
// a 34-bit three-term sum, compared to the region size, and the cached stack
// top, so back-to-back requests see each other's updates with no gaps.
// Writing region_base empties the allocator; writing region_bytes only moves
// the limit. Configuration is taken any cycle (csr_ready is always high) and
// is only meant to be written while no request is in flight.
module aligned_stack_allocator #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_request_bytes,
   input  logic [2:0]  req_align_log2,
   input  logic [31:0] req_release_address,
   // response channel
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_block_address,
   output logic [31:0] rsp_used_bytes,
   output logic [6:0]  rsp_live_blocks,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import asc_pkg::*;

   localparam int CW = $clog2(MAX_BLOCKS + 1);

   // input register
   logic        item_vld_ff;
   logic        kind_ff;
   logic [31:0] req_bytes_ff;
   logic [2:0]  align_log2_ff;
   logic [31:0] rel_addr_ff;

   // allocator state and registers
   logic [31:0] top_ff, top_in;
   logic [31:0] used_ff, used_in;
   logic [31:0] size_ff;

   // response register
   logic        rsp_vld_ff;
   logic [1:0]  status_ff;
   logic [31:0] addr_ff;
   logic [31:0] used_out_ff;
   logic [6:0]  live_ff;

   logic           csr_wr;
   logic           base_wr;
   stack_cmd_type  stk_cmd;
   logic [CW-1:0]  stk_count;
   logic [CW-1:0]  stk_count_next;
   logic [ADJ_W-1:0] stk_top;
   logic [ADJ_W-1:0] adj;
   logic [33:0]    need_sum;
   logic [31:0]    grant_addr;
   status_type     status;
   logic [31:0]    addr_out;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign base_wr   = csr_wr && (csr_index == CSR_REGION_BASE);

   // capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= start && !busy;
      end
      if (start && !busy) begin
         kind_ff       <= req_kind;
         req_bytes_ff  <= req_request_bytes;
         align_log2_ff <= req_align_log2;
         rel_addr_ff   <= req_release_address;
      end
   end

   // adjustment and region check for an allocate
   assign adj        = header_adjust(top_ff[6:0], align_log2_ff);
   assign need_sum   = {2'b00, used_ff} + 34'(adj) + {2'b00, req_bytes_ff};
   assign grant_addr = top_ff + 32'(adj);

   always_comb begin
      top_in   = top_ff;
      used_in  = used_ff;
      stk_cmd  = '0;
      status   = ST_OK;
      addr_out = '0;
      if (base_wr) begin
         top_in        = csr_data;
         used_in       = '0;
         stk_cmd.clear = 1'b1;
      end else if (item_vld_ff) begin
         if (kind_ff == KIND_ALLOC) begin
            if (stk_count == CW'(MAX_BLOCKS)) begin
               status = ST_STACK_FULL;
            end else if (need_sum > {2'b00, size_ff}) begin
               status = ST_REGION_FULL;
            end else begin
               addr_out     = grant_addr;
               top_in       = grant_addr + req_bytes_ff;
               used_in      = used_ff + req_bytes_ff + 32'(adj);
               stk_cmd.push = 1'b1;
            end
         end else begin
            if (stk_count == '0) begin
               status = ST_EMPTY;
            end else begin
               // release address is trusted: roll back to where that block began
               used_in     = used_ff - ((top_ff - rel_addr_ff) + 32'(stk_top));
               top_in      = rel_addr_ff - 32'(stk_top);
               stk_cmd.pop = 1'b1;
            end
         end
      end
   end

   asc_stack #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (stk_cmd),
      .push_data (adj),
      .count     (stk_count),
      .count_next(stk_count_next),
      .top_data  (stk_top)
   );

   // state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff  <= '0;
         used_ff <= '0;
         size_ff <= 32'd65536;
      end else begin
         top_ff  <= top_in;
         used_ff <= used_in;
         if (csr_wr && (csr_index == CSR_REGION_BYTES)) begin
            size_ff <= csr_data;
         end
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= item_vld_ff && !base_wr;
      end
      status_ff   <= status;
      addr_ff     <= addr_out;
      used_out_ff <= used_in;
      live_ff     <= 7'(stk_count_next);
   end

   assign rsp_strobe        = rsp_vld_ff;
   assign rsp_status        = status_ff;
   assign rsp_block_address = addr_ff;
   assign rsp_used_bytes    = used_out_ff;
   assign rsp_live_blocks   = live_ff;

endmodule

>>> bench/aligned_stack_allocator_test.sv
// aligned_stack_allocator_test: self-checking bench for the aligned stack allocator.
// Needs asc_pkg and the aligned_stack_allocator RTL. A shadow class predicts each
// response word and checks it against what the block returns.
`timescale 1ns / 100ps

module aligned_stack_allocator_test;
   import asc_pkg::*;

   localparam int DEPTH       = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_PHASES  = 8;

   // per phase: word count, sender idle share, allocate share, share of wide requests
   localparam int PH_WORDS [NUM_PHASES] = '{250, 200, 60, 250, 300, 200, 200, 240};
   localparam int PH_IDLE  [NUM_PHASES] = '{0, 68, 0, 28, 68, 0, 28, 68};
   localparam int PH_ALLOC [NUM_PHASES] = '{60, 75, 50, 70, 85, 60, 60, 55};
   localparam int PH_WIDE  [NUM_PHASES] = '{22, 22, 22, 22, 2, 22, 22, 22};

   typedef struct {
      status_type  status;
      logic [31:0] block_address;
      logic [31:0] used_bytes;
      logic [6:0]  live_blocks;
   } alloc_reply_type;

   // shadow copy of the allocator: predicts one response word per request word
   class allocator_shadow_type;
      logic [31:0]     base_addr;
      logic [31:0]     limit_bytes;
      logic [31:0]     top_addr;
      logic [31:0]     in_use;
      int              live;
      logic [7:0]      pads [DEPTH];
      logic [31:0]     grants [$];
      alloc_reply_type replies [$];
      int              errors;

      function new();
         errors      = 0;
         base_addr   = 32'd0;
         limit_bytes = 32'd65536;
         top_addr    = 32'd0;
         in_use      = 32'd0;
         live        = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         if (idx == CSR_REGION_BASE) begin
            // new base empties the allocator
            base_addr = data;
            top_addr  = data;
            in_use    = 32'd0;
            live      = 0;
            grants.delete();
         end else if (idx == CSR_REGION_BYTES) begin
            limit_bytes = data;
         end
      endfunction

      // padding up to the alignment, grown by whole alignments to fit the header
      function logic [31:0] pad_for(logic [2:0] alog);
         logic [31:0] mask;
         logic [31:0] pad;
         logic [31:0] gap_left;
         mask = (32'd1 << alog) - 32'd1;
         pad  = (32'd0 - top_addr) & mask;
         if (pad < 32'(HEADER_BYTES)) begin
            gap_left = 32'(HEADER_BYTES) - pad;
            pad      = pad + ((gap_left + mask) & ~mask);
         end
         return pad;
      endfunction

      // bytes an allocate at this alignment could take exactly; negative if none
      function longint room(logic [2:0] alog);
         return longint'({32'd0, limit_bytes}) - longint'({32'd0, in_use})
                - longint'({32'd0, pad_for(alog)});
      endfunction

      function void note_request(logic kind, logic [31:0] req, logic [2:0] alog,
                                 logic [31:0] rel);
         alloc_reply_type r;
         logic [31:0]     pad;
         logic [63:0]     need;
         r.status        = ST_OK;
         r.block_address = 32'd0;
         if (kind == KIND_ALLOC) begin
            if (live >= DEPTH) begin
               r.status = ST_STACK_FULL;
            end else begin
               pad  = pad_for(alog);
               need = {32'd0, in_use} + {32'd0, pad} + {32'd0, req};
               if (need > {32'd0, limit_bytes}) begin
                  r.status = ST_REGION_FULL;
               end else begin
                  r.block_address = top_addr + pad;
                  pads[live]      = pad[7:0];
                  live++;
                  top_addr = r.block_address + req;
                  in_use   = in_use + req + pad;
                  grants.push_back(r.block_address);
               end
            end
         end else if (live == 0) begin
            r.status = ST_EMPTY;
         end else begin
            // release address is trusted, even when it is not the top block
            pad      = {24'd0, pads[live-1]};
            in_use   = in_use - ((top_addr - rel) + pad);
            top_addr = rel - pad;
            live--;
            void'(grants.pop_back());
         end
         r.used_bytes  = in_use;
         r.live_blocks = 7'(live);
         replies.push_back(r);
      endfunction

      function void check_reply(logic [1:0] st, logic [31:0] addr, logic [31:0] used,
                                logic [6:0] blocks);
         alloc_reply_type e;
         if (replies.size() == 0) begin
            $error("response word with none expected");
            errors++;
            return;
         end
         e = replies.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
         end
         if (addr !== e.block_address) begin
            $error("block_address: expected %h, actual %h", e.block_address, addr);
            errors++;
         end
         if (used !== e.used_bytes) begin
            $error("used_bytes: expected %h, actual %h", e.used_bytes, used);
            errors++;
         end
         if (blocks !== e.live_blocks) begin
            $error("live_blocks: expected %0d, actual %0d", e.live_blocks, blocks);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = KIND_ALLOC;
   logic [31:0] req_request_bytes = 32'd0;
   logic [2:0]  req_align_log2 = 3'd0;
   logic [31:0] req_release_address = 32'd0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_block_address;
   logic [31:0] rsp_used_bytes;
   logic [6:0]  rsp_live_blocks;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_REGION_BASE;
   logic [31:0] csr_data = 32'd0;

   int                   cycle_count = 0;
   allocator_shadow_type shadow = new();

   aligned_stack_allocator #(
      .MAX_BLOCKS(DEPTH)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_request_bytes   (req_request_bytes),
      .req_align_log2      (req_align_log2),
      .req_release_address (req_release_address),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_block_address   (rsp_block_address),
      .rsp_used_bytes      (rsp_used_bytes),
      .rsp_live_blocks     (rsp_live_blocks),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   // watchdog: a hung handshake or a lost response word ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // response words cannot be held off, so every strobe is checked on the spot
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         shadow.check_reply(rsp_status, rsp_block_address, rsp_used_bytes, rsp_live_blocks);
      end
   end

   // present one request word and hold it until the block takes it
   task automatic send_word(logic kind, logic [31:0] req, logic [2:0] alog,
                            logic [31:0] rel);
      @(negedge clock);
      start               <= 1'b1;
      req_kind            <= kind;
      req_request_bytes   <= req;
      req_align_log2      <= alog;
      req_release_address <= rel;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow.note_request(kind, req, alog, rel);
   endtask

   // drop start for an idle gap of length n
   task automatic go_idle(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // stop sending, let every predicted word come back, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (shadow.replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // the top block's address, or noise when nothing is outstanding
   function automatic logic [31:0] top_block();
      if (shadow.grants.size() != 0) return shadow.grants[$];
      return $urandom();
   endfunction

   // mostly well-formed allocate/release traffic with random sizes and alignments
   task automatic random_word(int alloc_pct, int wide_pct);
      logic        kind;
      logic [31:0] req;
      logic [31:0] rel;
      logic [2:0]  alog;
      longint      fit;
      int          pick;
      alog = 3'($urandom_range(0, 7));
      kind = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_RELEASE;
      fit  = shadow.room(alog);
      pick = $urandom_range(0, 99);
      if (pick < wide_pct / 2 && fit >= 0 && fit < 64'hFFFF_FFFF) begin
         // exact fit or one byte over
         req = 32'(fit) + 32'($urandom_range(0, 1));
      end else if (pick < wide_pct) begin
         req = $urandom();
      end else if (pick < wide_pct + 10) begin
         req = 32'd0;
      end else if (pick < 75) begin
         req = $urandom_range(1, 64);
      end else begin
         req = $urandom_range(65, 4096);
      end
      if (kind == KIND_RELEASE && shadow.grants.size() != 0 && $urandom_range(0, 99) >= 2) begin
         rel = shadow.grants[$];
      end else begin
         rel = $urandom();
      end
      send_word(kind, req, alog, rel);
   endtask

   // region settings per phase; size-only writes keep the outstanding blocks
   task automatic set_up_phase(int p);
      case (p)
         0: begin
            write_reg(CSR_REGION_BYTES, 32'd65536);
            write_reg(CSR_REGION_BASE, 32'd0);
         end
         1: begin
            // top runs past 2^32 and wraps
            write_reg(CSR_REGION_BYTES, 32'hFFFF_FFFF);
            write_reg(CSR_REGION_BASE, 32'hFFFF_FF00);
         end
         2: write_reg(CSR_REGION_BYTES, 32'd1);
         3: begin
            write_reg(CSR_REGION_BYTES, 32'd4096);
            write_reg(CSR_REGION_BASE, $urandom());
         end
         4: begin
            // small requests against a huge region: the stack fills first
            write_reg(CSR_REGION_BYTES, 32'hFFFF_FFFF);
            write_reg(CSR_REGION_BASE, 32'd0);
         end
         5: write_reg(CSR_REGION_BYTES, $urandom_range(2048, 65535));
         6: begin
            write_reg(CSR_REGION_BYTES, 32'hFFFF_FFFF);
            write_reg(CSR_REGION_BASE, 32'hFFFF_FFFF);
         end
         default: begin
            write_reg(CSR_REGION_BYTES, $urandom());
            write_reg(CSR_REGION_BASE, $urandom());
         end
      endcase
   endtask

   initial begin
      int burst;
      int gap;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words against the reset settings (base 0, 64 KiB)
      send_word(KIND_RELEASE, $urandom(), 3'd0, $urandom());   // nothing to release
      send_word(KIND_ALLOC, 32'd0, 3'd0, $urandom());          // zero bytes still pads
      send_word(KIND_ALLOC, 32'd1, 3'd1, $urandom());
      send_word(KIND_ALLOC, 32'd7, 3'd2, $urandom());
      send_word(KIND_ALLOC, 32'd100, 3'd3, $urandom());
      send_word(KIND_ALLOC, 32'd33, 3'd4, $urandom());
      send_word(KIND_ALLOC, 32'd0, 3'd5, $urandom());
      send_word(KIND_ALLOC, 32'd2, 3'd6, $urandom());
      send_word(KIND_ALLOC, 32'd255, 3'd7, $urandom());
      send_word(KIND_ALLOC, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF); // sum must not wrap
      send_word(KIND_ALLOC, 32'h8000_0000, 3'd0, 32'd0);
      send_word(KIND_ALLOC, 32'(shadow.room(3'd3)), 3'd3, $urandom()); // fills region
      send_word(KIND_ALLOC, 32'd0, 3'd0, $urandom());          // no room for padding
      send_word(KIND_RELEASE, 32'hFFFF_FFFF, 3'd7, top_block());
      send_word(KIND_RELEASE, 32'd0, 3'd0, top_block());
      send_word(KIND_RELEASE, $urandom(), 3'd4, top_block() + 32'd5); // wrong address
      send_word(KIND_RELEASE, $urandom(), 3'd2, top_block());
      send_word(KIND_ALLOC, 32'd16, 3'd4, 32'd0);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_up_phase(p);
         burst = 0;
         for (int i = 0; i < PH_WORDS[p]; i++) begin
            // idle phases still get runs of back-to-back words
            if (PH_IDLE[p] != 0 && burst == 0 && $urandom_range(0, 99) < 4) begin
               burst = $urandom_range(10, 30);
            end
            if (burst > 0) begin
               burst--;
            end else if ($urandom_range(0, 99) < PH_IDLE[p]) begin
               gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
               go_idle(gap);
            end
            random_word(PH_ALLOC[p], PH_WIDE[p]);
         end
         drain();
      end

      if (shadow.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/asc_pkg.sv
sv/asc_ram.sv
sv/asc_stack.sv
sv/aligned_stack_allocator.sv
bench/aligned_stack_allocator_test.sv
